@@ hdl/rmth_pkg.sv @@
// ----------------------------------------------------------------------------
// rmth_pkg
// shared constants, types and helpers of the running median unit
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int TOTAL_CAPACITY = 1024;
  localparam int SAMPLE_W       = 32;
  localparam int HALF_DEPTH     = TOTAL_CAPACITY / 2;
  localparam int ADDR_W         = $clog2(HALF_DEPTH);
  localparam int CNT_W          = $clog2(HALF_DEPTH + 1);
  localparam int HELD_W         = CNT_W + 1;
  localparam int MED_W          = SAMPLE_W + 2;
  localparam int OUT_MED_W      = 33;
  localparam int IDX_W          = ADDR_W + 2;

  typedef struct packed {
    logic                       ins;
    logic                       take;
    logic signed [SAMPLE_W-1:0] value;
  } heap_cmd_t;

  typedef struct packed {
    logic                       busy;
    logic signed [SAMPLE_W-1:0] top;
    logic [CNT_W-1:0]           count;
  } heap_sts_t;

  typedef enum logic [6:0] {
    H_IDLE  = 7'b0000001,
    H_UPRD  = 7'b0000010,
    H_UPCMP = 7'b0000100,
    H_UPEND = 7'b0001000,
    H_DNLST = 7'b0010000,
    H_DNRD  = 7'b0100000,
    H_DNCMP = 7'b1000000
  } heap_state_t;

  typedef enum logic [5:0] {
    C_IDLE   = 6'b000001,
    C_TAKEGO = 6'b000010,
    C_TAKEWT = 6'b000100,
    C_INSGO  = 6'b001000,
    C_INSWT  = 6'b010000,
    C_FIN    = 6'b100000
  } ctrl_state_t;

  function automatic logic goes_above(input logic signed [SAMPLE_W-1:0] a,
                                      input logic signed [SAMPLE_W-1:0] b,
                                      input logic is_max);
    goes_above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

@@ hdl/rmth_heap.sv @@
// ----------------------------------------------------------------------------
// rmth_heap
// bounded binary heap in a memory with registered reads, sift up and sift down
// ----------------------------------------------------------------------------
module rmth_heap import rmth_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      is_max,
  input  heap_cmd_t cmd,
  output heap_sts_t sts
);

  logic signed [SAMPLE_W-1:0] mem [HALF_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_a_r, rd_b_r;
  logic signed [SAMPLE_W-1:0] val_r, val_nxt, top_r;
  logic [ADDR_W-1:0]          idx_r, idx_nxt, rd_addr_a, rd_addr_b, waddr, parent;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [IDX_W-1:0]           child, child_b;
  logic signed [SAMPLE_W-1:0] wdata, pick;
  logic                       we, use_b;
  heap_state_t                st_r, st_nxt;

  assign parent  = ADDR_W'((idx_r - 1'b1) >> 1);
  assign child   = {idx_r, 1'b1};
  assign child_b = child + 1'b1;
  assign use_b   = (child_b < IDX_W'(cnt_r)) && goes_above(rd_b_r, rd_a_r, is_max);
  assign pick    = use_b ? rd_b_r : rd_a_r;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = val_r;
    rd_addr_a = parent;
    rd_addr_b = parent;
    case (st_r)
      H_IDLE: begin
        rd_addr_a = ADDR_W'(cnt_r - 1'b1);
        if (cmd.ins) begin
          cnt_nxt = cnt_r + 1'b1;
          val_nxt = cmd.value;
          idx_nxt = ADDR_W'(cnt_r);
          if (cnt_r == '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = cmd.value;
          end else begin
            st_nxt = H_UPRD;
          end
        end else if (cmd.take && cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          idx_nxt = '0;
          if (cnt_r != CNT_W'(1)) begin
            st_nxt = H_DNLST;
          end
        end
      end
      H_UPRD: begin
        st_nxt = H_UPCMP;
      end
      H_UPCMP: begin
        we = 1'b1;
        if (goes_above(val_r, rd_a_r, is_max)) begin
          wdata   = rd_a_r;
          idx_nxt = parent;
          st_nxt  = (parent == '0) ? H_UPEND : H_UPRD;
        end else begin
          st_nxt = H_IDLE;
        end
      end
      H_UPEND: begin
        we     = 1'b1;
        st_nxt = H_IDLE;
      end
      H_DNLST: begin
        val_nxt = rd_a_r;
        st_nxt  = H_DNRD;
      end
      H_DNRD: begin
        rd_addr_a = ADDR_W'(child);
        rd_addr_b = ADDR_W'(child_b);
        if (child >= IDX_W'(cnt_r)) begin
          we     = 1'b1;
          st_nxt = H_IDLE;
        end else begin
          st_nxt = H_DNCMP;
        end
      end
      H_DNCMP: begin
        we = 1'b1;
        if (goes_above(pick, val_r, is_max)) begin
          wdata   = pick;
          idx_nxt = use_b ? ADDR_W'(child_b) : ADDR_W'(child);
          st_nxt  = H_DNRD;
        end else begin
          st_nxt = H_IDLE;
        end
      end
      default: begin
        st_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= H_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    if (we && waddr == '0) begin
      top_r <= wdata;
    end
  end

  assign sts.busy  = (st_r != H_IDLE);
  assign sts.top   = top_r;
  assign sts.count = cnt_r;

endmodule

@@ hdl/running_median_two_heaps_unit.sv @@
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit
// running median of a signed sample stream over a max-heap and a min-heap
// ----------------------------------------------------------------------------
// Each accepted word inserts one sample and returns twice the running median
// with the number of samples held. A heap operation walks one level at a
// time through a single memory per heap (ten levels), and a rebalance runs
// one take-top followed by two inserts in parallel. Once 1024 samples are
// held, further samples are dropped and flagged. A new word is accepted
// while the previous result waits.
module running_median_two_heaps_unit import rmth_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_MED_W-1:0] out_median_doubled,
  output logic [HELD_W-1:0]           out_samples_held,
  output logic                        out_refused_full
);

  heap_cmd_t lo_cmd, up_cmd;
  heap_sts_t lo_sts, up_sts;
  ctrl_state_t st_r;

  logic signed [SAMPLE_W-1:0] samp_r, t_r;
  logic signed [MED_W-1:0]    med_r, med_calc;
  logic                       mv_r, mv_lower_r, dst_upper_r, refused_r;
  logic                       above, full;
  logic [HELD_W-1:0]          held;

  rmth_heap u_lower (.clk(clk), .rst_n(rst_n), .is_max(1'b1), .cmd(lo_cmd), .sts(lo_sts));
  rmth_heap u_upper (.clk(clk), .rst_n(rst_n), .is_max(1'b0), .cmd(up_cmd), .sts(up_sts));

  assign held     = HELD_W'(lo_sts.count) + HELD_W'(up_sts.count);
  assign full     = held >= HELD_W'(2 * HALF_DEPTH);
  assign above    = ($signed({{(MED_W-SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample}) <<< 1)
                    > med_r;
  assign in_ready = (st_r == C_IDLE);

  always_comb begin
    if (lo_sts.count == up_sts.count) begin
      med_calc = MED_W'(lo_sts.top) + MED_W'(up_sts.top);
    end else if (lo_sts.count > up_sts.count) begin
      med_calc = MED_W'(lo_sts.top) <<< 1;
    end else begin
      med_calc = MED_W'(up_sts.top) <<< 1;
    end
  end

  always_comb begin
    lo_cmd = '{ins: 1'b0, take: 1'b0, value: samp_r};
    up_cmd = '{ins: 1'b0, take: 1'b0, value: samp_r};
    case (st_r)
      C_TAKEGO: begin
        lo_cmd.take = mv_lower_r;
        up_cmd.take = !mv_lower_r;
      end
      C_INSGO: begin
        lo_cmd.ins = !dst_upper_r || mv_r;
        up_cmd.ins = dst_upper_r || mv_r;
        if (dst_upper_r) begin
          lo_cmd.value = t_r;
        end else begin
          up_cmd.value = t_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= C_IDLE;
      med_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (st_r)
        C_IDLE: begin
          if (in_valid) begin
            samp_r      <= in_sample;
            dst_upper_r <= above;
            mv_lower_r  <= lo_sts.count > up_sts.count;
            mv_r        <= (lo_sts.count > up_sts.count && !above) ||
                           (up_sts.count > lo_sts.count && above);
            refused_r   <= full;
            if (full) begin
              st_r <= C_FIN;
            end else if ((lo_sts.count > up_sts.count && !above) ||
                         (up_sts.count > lo_sts.count && above)) begin
              st_r <= C_TAKEGO;
            end else begin
              st_r <= C_INSGO;
            end
          end
        end
        C_TAKEGO: begin
          t_r  <= mv_lower_r ? lo_sts.top : up_sts.top;
          st_r <= C_TAKEWT;
        end
        C_TAKEWT: begin
          if (!lo_sts.busy && !up_sts.busy) begin
            st_r <= C_INSGO;
          end
        end
        C_INSGO: begin
          st_r <= C_INSWT;
        end
        C_INSWT: begin
          if (!lo_sts.busy && !up_sts.busy) begin
            st_r <= C_FIN;
          end
        end
        C_FIN: begin
          if (!out_valid || out_ready) begin
            if (!refused_r) begin
              med_r <= med_calc;
            end
            out_median_doubled <= refused_r ? OUT_MED_W'(med_r) : OUT_MED_W'(med_calc);
            out_samples_held   <= held;
            out_refused_full   <= refused_r;
            out_valid          <= 1'b1;
            st_r               <= C_IDLE;
          end
        end
        default: begin
          st_r <= C_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the two-heap running median unit
// ----------------------------------------------------------------------------
// A behavioral model keeps the held samples in two heaps and predicts the
// doubled median, the count and the refusal flag of every word. The bench
// runs directed extremes, a fill to capacity with refusals, and random
// streams under three idling patterns, after one reset and none between them.
module tb;
  import rmth_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic out_valid, out_ready;
  logic signed [OUT_MED_W-1:0] out_median_doubled;
  logic [HELD_W-1:0] out_samples_held;
  logic out_refused_full;

  running_median_two_heaps_unit u_dut (.*);

  typedef struct {
    logic signed [OUT_MED_W-1:0] med;
    logic [HELD_W-1:0] held;
    logic refused;
  } median_word_t;

  median_word_t median_q[$];
  longint lo_heap[HALF_DEPTH];
  longint hi_heap[HALF_DEPTH];
  int lo_n, hi_n;
  longint med2;
  int n_err, n_sent, n_checked, n_refused;
  int send_idle_pct, recv_idle_pct;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end

  function automatic bit above(longint a, longint b, bit is_max);
    return is_max ? a > b : a < b;
  endfunction

  task automatic heap_push(ref longint h[HALF_DEPTH], ref int n, input longint v,
                           input bit is_max);
    int i, p;
    i = n;
    n++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!above(v, h[p], is_max)) break;
      h[i] = h[p];
      i = p;
    end
    h[i] = v;
  endtask

  task automatic heap_pop(ref longint h[HALF_DEPTH], ref int n, input bit is_max,
                          output longint top);
    int i, c;
    longint last;
    i = 0;
    top = h[0];
    n--;
    last = h[n];
    forever begin
      c = 2 * i + 1;
      if (c >= n) break;
      if (c + 1 < n && above(h[c+1], h[c], is_max)) c++;
      if (!above(h[c], last, is_max)) break;
      h[i] = h[c];
      i = c;
    end
    if (n > 0) h[i] = last;
  endtask

  task automatic predict_median(input logic signed [SAMPLE_W-1:0] smp);
    median_word_t w;
    longint s, t;
    bit up;
    s = smp;
    w.refused = 0;
    if (lo_n + hi_n >= 2 * HALF_DEPTH) begin
      w.refused = 1;
      n_refused++;
    end else begin
      up = 2 * s > med2;
      if (lo_n == hi_n) begin
        if (up) begin
          heap_push(hi_heap, hi_n, s, 0);
          med2 = 2 * hi_heap[0];
        end else begin
          heap_push(lo_heap, lo_n, s, 1);
          med2 = 2 * lo_heap[0];
        end
      end else begin
        if (lo_n > hi_n) begin
          if (up) heap_push(hi_heap, hi_n, s, 0);
          else begin
            heap_pop(lo_heap, lo_n, 1, t);
            heap_push(hi_heap, hi_n, t, 0);
            heap_push(lo_heap, lo_n, s, 1);
          end
        end else begin
          if (up) begin
            heap_pop(hi_heap, hi_n, 0, t);
            heap_push(lo_heap, lo_n, t, 1);
            heap_push(hi_heap, hi_n, s, 0);
          end else heap_push(lo_heap, lo_n, s, 1);
        end
        med2 = lo_heap[0] + hi_heap[0];
      end
    end
    w.med = med2[OUT_MED_W-1:0];
    w.held = HELD_W'(lo_n + hi_n);
    median_q.push_back(w);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_sample <= smp;
    predict_median(smp);
    n_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    median_word_t e;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (median_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word med=%0d", out_median_doubled);
      end else begin
        e = median_q.pop_front();
        if (e.med !== out_median_doubled || e.held !== out_samples_held ||
            e.refused !== out_refused_full) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp med=%0d held=%0d ref=%0b got med=%0d held=%0d ref=%0b",
                     e.med, e.held, e.refused, out_median_doubled, out_samples_held,
                     out_refused_full);
        end
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom_range(200) - 100;
      1: return $urandom_range(3) == 0 ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_sample(0);
    send_sample(32'sh7fffffff);
    send_sample(32'sh80000000);
    send_sample(32'sh7fffffff);
    send_sample(32'sh7fffffff);
    send_sample(-1);
    send_sample(1);
    send_sample(32'sh80000000);
    send_sample(32'sh80000000);
    send_sample(32'sh55555555);
    send_sample(32'shaaaaaaaa);
    send_sample(0);
  endtask

  task automatic test_random(input int n_items, input int sidle, input int ridle);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    repeat (n_items) send_sample(rand_sample());
  endtask

  // fill to capacity then push refused words
  task automatic test_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (lo_n + hi_n < 2 * HALF_DEPTH) send_sample($urandom);
    repeat (20) send_sample(rand_sample());
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_sample = 0;
    out_ready = 0;
    lo_n = 0;
    hi_n = 0;
    med2 = 0;
    send_idle_pct = 25;
    recv_idle_pct = 86;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(300, 25, 86);
    test_random(300, 86, 25);
    test_random(200, 0, 0);
    test_fill();
    test_random(900, 25, 86);
    in_valid <= 0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d samples, checked %0d medians, %0d refused when full",
             n_sent, n_checked, n_refused);
    if (n_err == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
